>>> sv/pdhm_pkg.sv
// Shared types, register indexes and constants of the dithered hex mono stream.
`default_nettype none
package pdhm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FORMAT = 2'd2;

    // Luma weights in 0.16 fixed point.
    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LUMA  = 6'b000100,
        S_BLEND = 6'b001000,
        S_DITH  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    // One finished mono byte handed to the output buffer.
    typedef struct packed {
        logic       vld;
        logic [7:0] mono_byte;
        logic       last;
    } t_hex_push;

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'h30 + 7'(nib);
        end
        return 7'h37 + 7'(nib);
    endfunction

endpackage
`default_nettype wire

>>> sv/pdhm_grey.sv
// Two-stage grey conversion: luma weighting, then alpha blend over white (skipped in the 16-bit format).
`default_nettype none
module pdhm_grey (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_pixel,
    input  wire logic        i_format,
    output logic      [7:0]  o_grey
);

    logic [7:0]  w_r, w_g, w_b;
    logic [23:0] w_sum;
    logic [7:0]  r_luma, r_alpha, r_m2;
    logic        r_fmt, r_fmt2;
    logic [15:0] r_blend;
    logic [16:0] w_div;

    always_comb begin
        if (i_format) begin
            w_r = {i_pixel[15:11], 3'b000};
            w_g = {i_pixel[10:5], 2'b00};
            w_b = {i_pixel[4:0], 3'b000};
        end else begin
            w_r = i_pixel[23:16];
            w_g = i_pixel[15:8];
            w_b = i_pixel[7:0];
        end
        w_sum = 24'(pdhm_pkg::LUMA_R) * 24'(w_r) + 24'(pdhm_pkg::LUMA_G) * 24'(w_g)
              + 24'(pdhm_pkg::LUMA_B) * 24'(w_b);
    end

    always_ff @(posedge i_clk) begin
        r_luma  <= w_sum[23:16];
        r_alpha <= i_pixel[31:24];
        r_fmt   <= i_format;
        r_blend <= 16'({8'd0, r_alpha} * {8'd0, r_luma})
                 + 16'({8'd0, 8'd255 - r_alpha} * 16'd255);
        r_m2    <= r_luma;
        r_fmt2  <= r_fmt;
    end

    // Division by 255, exact for every dividend the blend can produce (at most 255 * 255).
    assign w_div  = 17'(r_blend) + 17'd1 + 17'(r_blend[15:8]);
    assign o_grey = r_fmt2 ? r_m2 : w_div[15:8];

endmodule
`default_nettype wire

>>> sv/pdhm_line_mem.sv
// Line memory holding the pending error of each column for the next row.
`default_nettype none
module pdhm_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/pdhm_hex_out.sv
// Output buffer that sends one mono byte as two ASCII hex characters.
`default_nettype none
module pdhm_hex_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pdhm_pkg::t_hex_push i_push,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [6:0]               o_hex_char,
    output logic                     o_last_char,
    output logic                     o_busy
);

    logic [1:0] r_cnt;
    logic [7:0] r_byte;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push.vld) begin
            r_cnt <= 2'd2;
        end else if (o_out_valid && i_out_ready) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_byte <= i_push.mono_byte;
            r_last <= i_push.last;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_busy      = o_out_valid;
    assign o_hex_char  = pdhm_pkg::hex_ascii((r_cnt == 2'd2) ? r_byte[7:4] : r_byte[3:0]);
    // Only the low-nibble word of the final byte carries the flag.
    assign o_last_char = r_last && (r_cnt == 2'd1);

endmodule
`default_nettype wire

>>> sv/pixel_dither_to_hex_mono_top.sv
// A pixel passes the luma, blend and dither states; every eighth one completes a byte.
// A new pixel is accepted only in the idle state, after the previous one has passed the
// grey pipeline and the line error memory read; a flush state retires the last column
// of each row. A pixel that completes a byte waits while words of the previous byte are
// still buffered. Reset (synchronous, active low) and every write to a defined register
// start a clearing pass over the line memory, during which no pixel is accepted.
`default_nettype none
module pixel_dither_to_hex_mono_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_pixel_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [6:0]       o_hex_char,
    output logic             o_last_char,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > 12) ? WW : 12;

    localparam logic [2:0] K_RIGHT = 3'd7;
    localparam logic [2:0] K_BL    = 3'd3;
    localparam logic [2:0] K_BELOW = 3'd5;
    localparam logic [2:0] K_BR    = 3'd1;

    function automatic logic signed [12:0] share16(input logic signed [12:0] e,
                                                   input logic [2:0] k);
        logic signed [16:0] p;
        logic [16:0] mag;
        logic [16:0] q;
        p   = e * $signed({1'b0, k});
        mag = p[16] ? 17'(-p) : 17'(p);
        q   = mag >> 4;
        return p[16] ? 13'(-q) : 13'(q);
    endfunction

    function automatic logic [11:0] sat12(input logic signed [13:0] v);
        if (v > 14'sd2047) begin
            return 12'h7FF;
        end
        if (v < -14'sd2048) begin
            return 12'h800;
        end
        return v[11:0];
    endfunction

    pdhm_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_col, n_col;
    logic [15:0]     r_row, n_row;
    logic [11:0]     r_rc, n_rc;
    logic [8:0]      r_diag, n_diag;
    logic [11:0]     r_hold, n_hold;
    logic [7:0]      r_shift, n_shift;
    logic [2:0]      r_phase, n_phase;
    logic [11:0]     r_cfg_w;
    logic [15:0]     r_cfg_h;
    logic            r_cfg_fmt;
    logic [31:0]     r_pixel;

    logic [CW-1:0]   w_wext;
    logic [WW-1:0]   w_weff;
    logic [15:0]     w_heff;
    logic [WW-1:0]   w_colp1;
    logic            w_last_col;
    logic            w_bottom;
    logic [7:0]      w_grey;
    logic [11:0]     w_rd;
    logic signed [13:0] w_old;
    logic            w_dark;
    logic signed [12:0] w_e;
    logic signed [12:0] w_s7, w_s3, w_s5, w_s1;
    logic [11:0]     w_hold_new;
    logic [15:0]     w_k;
    logic [WW-1:0]   w_tail;
    logic [5:0]      w_prod;
    logic [6:0]      w_near_sum;
    logic            w_near_end;
    logic [7:0]      w_dshift;
    logic            w_restart;
    logic            w_accept;
    logic            w_out_busy;
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_waddr;
    logic [11:0]     w_mem_wdata;
    pdhm_pkg::t_hex_push w_push;

    // Effective image size.
    always_comb begin
        w_wext = CW'(r_cfg_w);
        if (w_wext == '0) begin
            w_weff = WW'(1);
        end else if (w_wext > CW'(MAX_WIDTH)) begin
            w_weff = WW'(MAX_WIDTH);
        end else begin
            w_weff = WW'(w_wext);
        end
        w_heff = (r_cfg_h == 16'd0) ? 16'd1 : r_cfg_h;
    end

    assign w_colp1    = WW'(r_col) + WW'(1);
    assign w_last_col = (w_colp1 >= w_weff);
    assign w_bottom   = (({1'b0, r_row} + 17'd1) < {1'b0, w_heff});

    pdhm_grey u_grey (
        .i_clk    (i_clk),
        .i_pixel  (r_pixel),
        .i_format (r_cfg_fmt),
        .o_grey   (w_grey)
    );

    pdhm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (12)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (r_state == pdhm_pkg::S_BLEND),
        .i_raddr (r_col),
        .o_rdata (w_rd)
    );

    // Dithering arithmetic for the pixel in the dither state.
    always_comb begin
        w_old  = $signed({6'd0, w_grey}) + $signed({{2{w_rd[11]}}, w_rd})
               + $signed({{2{r_rc[11]}}, r_rc});
        w_dark = (w_old < 14'sd128);
        w_e    = w_dark ? w_old[12:0] : 13'(w_old - 14'sd255);
        w_s7   = share16(w_e, K_RIGHT);
        w_s3   = share16(w_e, K_BL);
        w_s5   = share16(w_e, K_BELOW);
        w_s1   = share16(w_e, K_BR);
        w_hold_new = w_bottom ? sat12(14'($signed(r_diag)) + 14'(w_s5)) : 12'd0;
        w_dshift   = {r_shift[6:0], w_dark};
    end

    // Fewer than eight pixels follow this one in the image.
    always_comb begin
        w_k        = w_heff - 16'd1 - r_row;
        w_tail     = w_weff - w_colp1;
        w_prod     = 6'(w_k[2:0] * w_weff[2:0]);
        w_near_sum = 7'(w_prod) + 7'(w_tail[2:0]);
        if (w_k == 16'd0) begin
            w_near_end = (w_tail < WW'(8));
        end else begin
            w_near_end = (w_k < 16'd8) && (w_weff < WW'(8)) && (w_near_sum < 7'd8);
        end
    end

    assign o_in_ready  = (r_state == pdhm_pkg::S_IDLE) && !(w_out_busy && (r_phase == 3'd7));
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                pdhm_pkg::CFG_WIDTH, pdhm_pkg::CFG_HEIGHT, pdhm_pkg::CFG_FORMAT: begin
                    w_restart = 1'b1;
                end
                default: begin
                    w_restart = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_col   = r_col;
        n_row   = r_row;
        n_rc    = r_rc;
        n_diag  = r_diag;
        n_hold  = r_hold;
        n_shift = r_shift;
        n_phase = r_phase;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_col;
        w_mem_wdata = 12'd0;
        w_push.vld       = 1'b0;
        w_push.mono_byte = w_dshift;
        w_push.last      = w_near_end;
        unique case (r_state)
            pdhm_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                if (r_clr == AW'(MAX_WIDTH - 1)) begin
                    n_state = pdhm_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            pdhm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = pdhm_pkg::S_LUMA;
                end
            end
            pdhm_pkg::S_LUMA: begin
                n_state = pdhm_pkg::S_BLEND;
            end
            pdhm_pkg::S_BLEND: begin
                n_state = pdhm_pkg::S_DITH;
            end
            pdhm_pkg::S_DITH: begin
                // The left neighbor below is final once it has its 3/16 share.
                if (r_col != '0) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_col - AW'(1);
                    w_mem_wdata = w_bottom ? sat12(14'($signed(r_hold)) + 14'(w_s3)) : 12'd0;
                end
                w_push.vld = (r_phase == 3'd7);
                n_shift = w_dshift;
                n_phase = r_phase + 3'd1;
                n_hold  = w_hold_new;
                if (w_last_col) begin
                    n_rc    = 12'd0;
                    n_diag  = 9'd0;
                    n_state = pdhm_pkg::S_FLUSH;
                end else begin
                    n_rc    = sat12(14'(w_s7));
                    n_diag  = w_bottom ? w_s1[8:0] : 9'd0;
                    n_col   = r_col + AW'(1);
                    n_state = pdhm_pkg::S_IDLE;
                end
            end
            pdhm_pkg::S_FLUSH: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_col;
                w_mem_wdata = r_hold;
                n_col = '0;
                if (w_bottom) begin
                    n_row = r_row + 16'd1;
                end else begin
                    n_row   = 16'd0;
                    n_phase = 3'd0;
                    n_shift = 8'd0;
                end
                n_state = pdhm_pkg::S_IDLE;
            end
            default: begin
                n_state = pdhm_pkg::S_CLEAR;
                n_clr   = '0;
            end
        endcase
        if (w_restart) begin
            n_state = pdhm_pkg::S_CLEAR;
            n_clr   = '0;
            n_col   = '0;
            n_row   = 16'd0;
            n_rc    = 12'd0;
            n_diag  = 9'd0;
            n_hold  = 12'd0;
            n_shift = 8'd0;
            n_phase = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pdhm_pkg::S_CLEAR;
            r_clr     <= '0;
            r_col     <= '0;
            r_row     <= 16'd0;
            r_rc      <= 12'd0;
            r_diag    <= 9'd0;
            r_hold    <= 12'd0;
            r_shift   <= 8'd0;
            r_phase   <= 3'd0;
            r_cfg_w   <= 12'd1;
            r_cfg_h   <= 16'd1;
            r_cfg_fmt <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_col   <= n_col;
            r_row   <= n_row;
            r_rc    <= n_rc;
            r_diag  <= n_diag;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_phase <= n_phase;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pdhm_pkg::CFG_WIDTH:  r_cfg_w   <= i_cfg_data[11:0];
                    pdhm_pkg::CFG_HEIGHT: r_cfg_h   <= i_cfg_data;
                    pdhm_pkg::CFG_FORMAT: r_cfg_fmt <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pixel <= i_pixel_word;
        end
    end

    pdhm_hex_out u_hex_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_hex_char  (o_hex_char),
        .o_last_char (o_last_char),
        .o_busy      (w_out_busy)
    );

`ifndef SYNTHESIS
    a_push_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> !w_out_busy)
        else $error("mono byte pushed while the output buffer still holds words");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pdhm_pkg::S_CLEAR) |-> (WW'(r_col) < w_weff))
        else $error("column position outside the image width");

    a_row_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pdhm_pkg::S_DITH) && w_last_col && !w_restart)
        |=> (r_state == pdhm_pkg::S_FLUSH))
        else $error("last column of a row not retired to the line memory");
`endif

endmodule
`default_nettype wire
